// ----- hw/rtl/mctp_pkg.sv -----
// Shared types, constants and the configuration bundle of the timestamp PWM core.
// Used by mctp_cfg, mctp_chan and multi_channel_timestamp_pwm_core; no dependencies.
`default_nettype none

package mctp_pkg;

    // Number of channel slots and how many of them are built
    localparam int NUM_SLOTS = 4;
    localparam int CHANNELS  = 4;

    typedef logic [31:0] t_time;
    typedef logic [23:0] t_period;
    typedef logic [7:0]  t_duty;
    typedef logic [2:0]  t_cfg_idx;

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_ENABLE      = 3'd0;
    localparam t_cfg_idx CFG_DUTY        = 3'd1;
    localparam t_cfg_idx CFG_PERIOD_BASE = 3'd2;

    localparam t_duty   DUTY_ZERO    = 8'd0;
    localparam t_duty   DUTY_FULL    = 8'd255;
    localparam t_period PERIOD_RESET = 24'd20000;
    // Rounding slack of floor(x/255): e >= floor(p/255) <=> 255*e >= p - 254
    localparam t_time   ON_ROUND     = 32'(DUTY_FULL - 8'd1);

    // Per-channel settings as the evaluators see them
    typedef struct packed {
        logic  [NUM_SLOTS-1:0]       enable;
        t_duty [NUM_SLOTS-1:0]       duty;
        t_time [NUM_SLOTS-1:0]       on_thr;   // 255*elapsed at which high ends
        t_time [NUM_SLOTS-1:0]       off_thr;  // 255*elapsed at which low ends
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/multi_channel_timestamp_pwm_core.sv -----
// Top level of the multi-channel timestamp PWM core.
// Depends on mctp_pkg, mctp_cfg and mctp_chan.
//
// The core takes one microsecond timestamp per item and returns one item with
// the level of every channel and a mask of channels that changed on that tick.
// It accepts an item every clock while the result channel is not stalled; each
// item is held in the input register and leaves through the output register.
// The per-channel phase compare reads and updates the channel state in the
// same cycle. A stalled result holds in the output register and the input
// register refills behind it. Configuration writes are taken whenever ready
// is high, which it is out of reset; the segment thresholds are registered
// from the written period and duty registers.
`default_nettype none

module multi_channel_timestamp_pwm_core
    import mctp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // timestamp items
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_time    i_now_us,
    // result items
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output logic [3:0]    o_pin_levels,
    output logic [3:0]    o_changed_mask,
    // configuration writes
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_time    i_cfg_data
);

    t_cfg                 w_cfg;
    logic                 w_advance;
    logic [NUM_SLOTS-1:0] w_level;
    logic [NUM_SLOTS-1:0] w_changed;

    logic                 r_in_valid;
    t_time                r_now;
    logic                 r_out_valid;
    logic [3:0]           r_pins;
    logic [3:0]           r_changed;

    assign o_cfg_ready = i_rst_n;

    mctp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Move the held tick forward whenever the output register is free
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !w_advance);

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_chan
        if (i < CHANNELS) begin : g_on
            mctp_chan u_chan (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_advance (w_advance),
                .i_now     (r_now),
                .i_enable  (w_cfg.enable[i]),
                .i_duty    (w_cfg.duty[i]),
                .i_on_thr  (w_cfg.on_thr[i]),
                .i_off_thr (w_cfg.off_thr[i]),
                .o_level   (w_level[i]),
                .o_changed (w_changed[i])
            );
        end else begin : g_off
            assign w_level[i]   = 1'b0;
            assign w_changed[i] = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_now <= i_now_us;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_pins    <= w_level;
            r_changed <= w_changed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pin_levels   = r_pins;
    assign o_changed_mask = r_changed;

    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("advanced item did not reach the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_advance)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/mctp_cfg.sv -----
// Configuration registers and per-channel segment thresholds.
// Depends on mctp_pkg.
`default_nettype none

module mctp_cfg
    import mctp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_valid,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_time    i_cfg_data,
    output t_cfg          o_cfg
);

    logic    [NUM_SLOTS-1:0] r_enable;
    t_time                   r_duty_levels;
    t_period [NUM_SLOTS-1:0] r_period;
    t_time   [NUM_SLOTS-1:0] r_on_thr;
    t_time   [NUM_SLOTS-1:0] r_off_thr;
    t_time   [NUM_SLOTS-1:0] n_on_thr;
    t_time   [NUM_SLOTS-1:0] n_off_thr;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= '0;
            r_duty_levels <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_period[i] <= PERIOD_RESET;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLE) begin
                r_enable <= i_cfg_data[NUM_SLOTS-1:0];
            end
            if (i_cfg_index == CFG_DUTY) begin
                r_duty_levels <= i_cfg_data;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i_cfg_index == CFG_PERIOD_BASE + t_cfg_idx'(i)) begin
                    r_period[i] <= i_cfg_data[23:0];
                end
            end
        end
    end

    // Thresholds scaled by 255 so the channel compare needs no divider
    always_comb begin
        t_time prod;
        t_duty duty;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            duty         = r_duty_levels[8*i +: 8];
            prod         = t_time'(duty) * t_time'(r_period[i]);
            n_on_thr[i]  = (prod > ON_ROUND) ? prod - ON_ROUND : '0;
            n_off_thr[i] = t_time'(DUTY_FULL - duty) * t_time'(r_period[i]);
        end
    end

    // Register the thresholds, recomputed every cycle
    always_ff @(posedge i_clk) begin
        r_on_thr  <= n_on_thr;
        r_off_thr <= n_off_thr;
    end

    always_comb begin
        o_cfg.enable  = r_enable;
        o_cfg.on_thr  = r_on_thr;
        o_cfg.off_thr = r_off_thr;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_cfg.duty[i] = r_duty_levels[8*i +: 8];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mctp_chan.sv -----
// One PWM channel: level, phase start and enable history, with its segment compare.
// Depends on mctp_pkg.
`default_nettype none

module mctp_chan
    import mctp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire t_time i_now,
    input  wire logic  i_enable,
    input  wire t_duty i_duty,
    input  wire t_time i_on_thr,
    input  wire t_time i_off_thr,
    output logic       o_level,
    output logic       o_changed
);

    logic  r_level;
    logic  r_was_en;
    t_time r_phase;
    logic  n_level;
    logic  n_was_en;
    t_time n_phase;

    // Evaluate the channel for the current tick
    always_comb begin
        logic        base_lvl;
        t_time       elapsed;
        logic [39:0] e255;
        logic [39:0] thr;
        base_lvl = r_was_en ? r_level : 1'b0;
        elapsed  = r_was_en ? i_now - r_phase : '0;
        e255     = {elapsed, 8'h00} - {8'h00, elapsed};
        thr      = {8'h00, (base_lvl ? i_on_thr : i_off_thr)};
        n_level  = base_lvl;
        n_was_en = r_was_en;
        n_phase  = r_was_en ? r_phase : i_now;
        if (!i_enable) begin
            n_level  = 1'b0;
            n_was_en = 1'b0;
            n_phase  = r_phase;
        end else begin
            n_was_en = 1'b1;
            priority if (i_duty == DUTY_ZERO) begin
                n_level = 1'b0;
                n_phase = i_now;
            end else if (i_duty == DUTY_FULL) begin
                n_level = 1'b1;
                n_phase = i_now;
            end else if (e255 >= thr) begin
                n_level = !base_lvl;
                n_phase = i_now;
            end else begin
                // hold the level until the segment has run out
                n_level = base_lvl;
            end
        end
    end

    assign o_level   = n_level;
    assign o_changed = n_level != r_level;

    // Commit state when the tick moves on to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b0;
            r_was_en <= 1'b0;
            r_phase  <= '0;
        end else if (i_advance) begin
            r_level  <= n_level;
            r_was_en <= n_was_en;
            r_phase  <= n_phase;
        end
    end

    a_disabled_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_enable) |=> (!r_level && !r_was_en))
        else $error("disabled channel not cleared");

    a_full_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_enable && i_duty == DUTY_FULL)
        |=> (r_level && r_phase == $past(i_now)))
        else $error("full duty channel not held high at now");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_level) && $stable(r_was_en) && $stable(r_phase)))
        else $error("channel state moved without a tick");

endmodule

`default_nettype wire

// ----- tb/mctp_pwm_checker.sv -----
// Checker for the timestamp PWM core: watches the config, timestamp and result channels.
// Predicts levels and change masks per accepted tick and compares them; needs mctp_pkg.
`default_nettype none

module mctp_pwm_checker
    import mctp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_stall,
    input  wire t_time    i_now_us,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_stall,
    input  wire logic [3:0] i_pin_levels,
    input  wire logic [3:0] i_changed_mask,
    input  wire logic     i_cfg_valid,
    input  wire logic     i_cfg_ready,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_time    i_cfg_data,
    output int            o_pending,
    output int            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] levels;
        logic [3:0] changed;
    } t_pwm_result;

    // Register copy
    logic [3:0] enable_q;
    t_time      duty_word;
    t_period    period_q [NUM_SLOTS];

    // Channel state
    logic       level_q  [NUM_SLOTS];
    t_time      phase_q  [NUM_SLOTS];
    logic       armed_q  [NUM_SLOTS];

    t_pwm_result expected_levels_q [$];
    int          fail_count = 0;

    // floor(duty * period / 255)
    function automatic t_time high_ticks(t_duty duty, t_period period);
        logic [63:0] prod;
        prod = 64'(duty) * 64'(period);
        return t_time'(prod / 64'd255);
    endfunction

    // Advance every channel by one tick and return the levels and change mask
    function automatic t_pwm_result advance_channels(t_time now);
        t_pwm_result res;
        logic        lvl;
        logic        old;
        t_duty       duty;
        t_time       high_len;
        t_time       seg_len;
        t_time       elapsed;
        res = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            old = level_q[ch];
            lvl = old;
            if (!enable_q[ch]) begin
                lvl = 1'b0;
                armed_q[ch] = 1'b0;
            end else begin
                duty = duty_word[8*ch +: 8];
                // restart a channel on its first enabled tick
                if (!armed_q[ch]) begin
                    armed_q[ch] = 1'b1;
                    lvl = 1'b0;
                    phase_q[ch] = now;
                end
                if (duty == DUTY_ZERO) begin
                    lvl = 1'b0;
                    phase_q[ch] = now;
                end else if (duty == DUTY_FULL) begin
                    lvl = 1'b1;
                    phase_q[ch] = now;
                end else begin
                    high_len = high_ticks(duty, period_q[ch]);
                    elapsed  = now - phase_q[ch];
                    seg_len  = lvl ? high_len : t_time'(period_q[ch]) - high_len;
                    if (elapsed >= seg_len) begin
                        lvl = !lvl;
                        phase_q[ch] = now;
                    end
                end
            end
            level_q[ch]      = lvl;
            res.levels[ch]  = lvl;
            res.changed[ch] = (lvl != old);
        end
        return res;
    endfunction

    // Mirror a register write; unused indexes drop
    function automatic void store_register(t_cfg_idx idx, t_time data);
        case (idx)
            CFG_ENABLE: begin
                enable_q = data[3:0];
            end
            CFG_DUTY: begin
                duty_word = data;
            end
            default: begin
                if (idx >= CFG_PERIOD_BASE && idx < CFG_PERIOD_BASE + NUM_SLOTS)
                    period_q[2'(idx - CFG_PERIOD_BASE)] = data[23:0];
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pwm_result want;
        if (!i_rst_n) begin
            enable_q  = '0;
            duty_word = '0;
            for (int ch = 0; ch < NUM_SLOTS; ch++) begin
                period_q[ch] = PERIOD_RESET;
                level_q[ch]  = 1'b0;
                phase_q[ch]  = '0;
                armed_q[ch]  = 1'b0;
            end
            expected_levels_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                store_register(i_cfg_index, i_cfg_data);

            // check a result against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_levels_q.size() == 0) begin
                    $display("%0t: unexpected item: pin_levels %h changed_mask %h",
                             $time, i_pin_levels, i_changed_mask);
                    fail_count++;
                end else begin
                    want = expected_levels_q.pop_front();
                    if (want.levels !== i_pin_levels) begin
                        $display("%0t: pin_levels expected %h got %h",
                                 $time, want.levels, i_pin_levels);
                        fail_count++;
                    end
                    if (want.changed !== i_changed_mask) begin
                        $display("%0t: changed_mask expected %h got %h",
                                 $time, want.changed, i_changed_mask);
                        fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_levels_q.push_back(advance_channels(i_now_us));
        end
        o_pending    <= expected_levels_q.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Top of the timestamp PWM core testbench: clock, reset, stimulus and verdict.
// Depends on mctp_pkg, multi_channel_timestamp_pwm_core and mctp_pwm_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mctp_pkg::*;

    localparam int       CYCLE_LIMIT   = 300000;
    localparam int       ITEMS_PER_SET = 55;
    localparam int       SETS_PER_MODE = 5;
    localparam int       DRAIN_CYCLES  = 8;
    localparam t_cfg_idx CFG_SPARE_LO  = 3'd6;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_time      now_us    = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] pin_levels;
    logic [3:0] changed_mask;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    t_cfg_idx   cfg_index = '0;
    t_time      cfg_data  = '0;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    multi_channel_timestamp_pwm_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_now_us       (now_us),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pin_levels   (pin_levels),
        .o_changed_mask (changed_mask),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    mctp_pwm_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_now_us       (now_us),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pin_levels   (pin_levels),
        .i_changed_mask (changed_mask),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Count cycles and stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Stall the result channel at random
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Write one register; valid stays high for a following write
    task automatic write_reg(input t_cfg_idx idx, input t_time data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted item has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Drain, then write every register and one unused index
    task automatic program_all(input t_time en_word, input t_time duty_word,
                               input t_time periods [NUM_SLOTS]);
        wait_drained();
        write_reg(CFG_ENABLE, en_word);
        write_reg(CFG_DUTY, duty_word);
        for (int ch = 0; ch < NUM_SLOTS; ch++)
            write_reg(t_cfg_idx'(CFG_PERIOD_BASE + ch), periods[ch]);
        write_reg(t_cfg_idx'(CFG_SPARE_LO + $urandom_range(0, 1)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Send one timestamp item after a random gap; valid stays high afterwards
    task automatic send_tick(input t_time stamp);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_us   <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial begin
        t_time periods [NUM_SLOTS];
        t_time stamp;
        t_time word;
        t_time duty_word;
        int    pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mid duty, duty one with zero period, duty zero, full duty, wrap
        periods = '{32'd10, 32'd0, 32'hFFFF_FFFF, 32'd3};
        program_all(32'hFFFF_FFFF, 32'hFF00_0180, periods);
        send_tick(32'hFFFF_FFF8);
        send_tick(32'hFFFF_FFF8);
        send_tick(32'hFFFF_FFFB);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0002);
        send_tick(32'h0000_0003);
        send_tick(32'h0000_0008);
        send_tick(32'h0000_000D);
        send_tick(32'h8000_0000);

        // Directed: partial enable, duty 254 at max period, large jumps
        periods = '{32'hFF00_0000, 32'h00FF_FFFF, 32'd1, 32'd255};
        program_all(32'h0000_000A, 32'h8007_FE00, periods);
        send_tick(32'h0000_0000);
        send_tick(32'h0000_0001);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h00FF_FFFE);
        send_tick(32'h0100_0000);
        send_tick(32'h0100_0001);

        // Directed: everything off, then everything back on at full duty
        periods = '{32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF};
        program_all(32'h0000_0000, 32'hFFFF_FFFF, periods);
        send_tick(32'h5555_5555);
        send_tick(32'hAAAA_AAAA);
        send_tick(32'h0F0F_0F0F);
        program_all(32'h0000_000F, 32'hFFFF_FFFF, periods);
        send_tick(32'hF0F0_F0F0);
        send_tick(32'hF0F0_F0F1);

        // Random: idle modes, several settings each, mostly short periods
        stamp = $urandom();
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            for (int set = 0; set < SETS_PER_MODE; set++) begin
                for (int ch = 0; ch < NUM_SLOTS; ch++) begin
                    word = $urandom();
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        word[23:0] = '0;
                    else if (pick == 2)
                        word[23:0] = 24'($urandom_range(60, 3000));
                    else if (pick > 2)
                        word[23:0] = 24'($urandom_range(1, 40));
                    periods[ch] = word;
                end
                for (int ch = 0; ch < NUM_SLOTS; ch++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        duty_word[8*ch +: 8] = DUTY_ZERO;
                    else if (pick == 1)
                        duty_word[8*ch +: 8] = DUTY_FULL;
                    else if (pick == 2)
                        duty_word[8*ch +: 8] = DUTY_FULL - 8'd1;
                    else if (pick == 3)
                        duty_word[8*ch +: 8] = 8'd1;
                    else
                        duty_word[8*ch +: 8] = 8'($urandom_range(0, 255));
                end
                word = $urandom();
                if ($urandom_range(0, 2) == 0)
                    word[3:0] = 4'hF;
                program_all(word, duty_word, periods);

                for (int k = 0; k < ITEMS_PER_SET; k++) begin
                    // in the second set of each mode, hold the sender mid-stream until all items return
                    if (set == 1 && k == ITEMS_PER_SET / 2)
                        wait_drained();
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        stamp = stamp + $urandom_range(0, 12);
                    else if (pick < 95)
                        stamp = stamp + $urandom_range(0, 3000);
                    else
                        stamp = $urandom();
                    send_tick(stamp);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
